[rtl/assert_macros.svh]
// Assertion macros shared by the flanger RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define SLF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be true at a rising edge outside reset.
`define SLF_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/slf_pkg.sv]
// Shared constants, types and the sine table builder for the flanger.
// No dependencies; used by slf_ctrl, slf_dpath and sine_lfo_flanger_top.
package slf_pkg;

	// Sample and delay geometry
	localparam int SAMPLE_W    = 16;
	localparam int DELAY_MAX   = 256;
	localparam int RING_DEPTH  = DELAY_MAX + 2;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int COUNT_MAX   = DELAY_MAX + 2;
	localparam int COUNT_W     = $clog2(COUNT_MAX + 1);

	// LFO and sine table
	localparam int PHASE_W     = 32;
	localparam int SINE_DEPTH  = 1024;
	localparam int SINE_AW     = $clog2(SINE_DEPTH);
	localparam int SINE_W      = 16;

	// Delay in Q.8: integer part and interpolation fraction
	localparam int FRAC_W      = 8;
	localparam int DINT_W      = $clog2(DELAY_MAX);
	localparam int DQ_W        = DINT_W + FRAC_W;
	localparam int DQ_SHIFT    = SINE_W - FRAC_W;
	localparam int DM_W        = $clog2(DELAY_MAX + 1);

	// Gain path: Q2.14 gain times Q.23 mix gives Q.37, rounded back to Q.15
	localparam int GAIN_W      = 16;
	localparam int GAIN_FRAC   = 14;
	localparam int MIX_W       = SAMPLE_W + FRAC_W + 2;
	localparam int PROD_W      = GAIN_W + MIX_W;
	localparam int RND_SHIFT   = FRAC_W + GAIN_FRAC;
	localparam int ADD_W       = PROD_W - RND_SHIFT;
	localparam int SUM_W       = ADD_W + 1;

	// Configuration register map
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_MIX_GAIN   = 2'd1
	} cfg_reg_t;

	// One command line per sequencer step
	typedef struct packed {
		logic accept;
		logic sine;
		logic delay;
		logic addr;
		logic rda;
		logic rdb;
		logic mix;
		logic mul;
		logic out_load;
	} slf_cmd_t;

	typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_DEPTH];

	// sin(pi/2 * x) for x in Q16 0..65536, result Q15 clamped to 0..32767.
	// Odd degree-9 polynomial, Q30 coefficients, truncating Horner steps.
	function automatic longint quarter_sine(longint x);
		longint x2;
		longint p;
		x2 = (x * x) / 65536;
		p = 172228;
		p = -5027044 + (p * x2) / 65536;
		p = 85569278 + (p * x2) / 65536;
		p = -693598676 + (p * x2) / 65536;
		p = 1686629713 + (p * x2) / 65536;
		p = (p * x) / 65536;
		if (p < 0) begin
			p = 0;
		end
		p = (p + 16384) / 32768;
		if (p > 32767) begin
			p = 32767;
		end
		return p;
	endfunction

	// Full-wave table from the quarter wave by folding the index.
	function automatic sine_tab_t build_sine();
		sine_tab_t tab;
		longint u;
		longint q;
		longint r;
		longint x;
		longint v;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			u = longint'(k) * 4;
			q = u / SINE_DEPTH;
			r = u % SINE_DEPTH;
			x = (r * 65536) / SINE_DEPTH;
			if (q % 2 == 1) begin
				x = 65536 - x;
			end
			v = quarter_sine(x);
			if ((q / 2) % 2 == 1) begin
				v = -v;
			end
			tab[k] = v[SINE_W-1:0];
		end
		return tab;
	endfunction

endpackage

[rtl/slf_ctrl.sv]
// Sequencer for the flanger: one-hot state machine issuing datapath commands.
// Depends on slf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slf_ctrl import slf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output slf_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SINE  = 9'b000000010,
		ST_DELAY = 9'b000000100,
		ST_ADDR  = 9'b000001000,
		ST_RDA   = 9'b000010000,
		ST_RDB   = 9'b000100000,
		ST_MIX   = 9'b001000000,
		ST_MUL   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// Output register can take a new result when empty or being drained
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SINE;
			ST_SINE:  state_d = ST_DELAY;
			ST_DELAY: state_d = ST_ADDR;
			ST_ADDR:  state_d = ST_RDA;
			ST_RDA:   state_d = ST_RDB;
			ST_RDB:   state_d = ST_MIX;
			ST_MIX:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd.accept   = in_valid && (state_q == ST_IDLE);
		cmd.sine     = (state_q == ST_SINE);
		cmd.delay    = (state_q == ST_DELAY);
		cmd.addr     = (state_q == ST_ADDR);
		cmd.rda      = (state_q == ST_RDA);
		cmd.rdb      = (state_q == ST_RDB);
		cmd.mix      = (state_q == ST_MIX);
		cmd.mul      = (state_q == ST_MUL);
		cmd.out_load = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SLF_ASSERT(a_accept_starts, cmd.accept |=> state_q == ST_SINE, "accepted transfer did not start the sequence")
	`SLF_ASSERT(a_stall_holds, state_q == ST_OUT && !out_free |=> state_q == ST_OUT && out_valid_q, "result step left while output was stalled")
	`SLF_ASSERT(a_load_shows, cmd.out_load |=> out_valid_q && state_q == ST_IDLE, "loaded result not presented")

endmodule

[rtl/slf_dpath.sv]
// Flanger datapath: config registers, LFO, sine ROM, history ring, mix and gain.
// Depends on slf_pkg; driven by slf_ctrl through slf_cmd_t.
module slf_dpath import slf_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slf_cmd_t                     cmd,
	input  logic signed [SAMPLE_W-1:0]   sample_in,
	input  logic                         start_of_signal,
	input  logic                         cfg_we,
	input  logic        [CFG_IDX_W-1:0]  cfg_index,
	input  logic        [CFG_DATA_W-1:0] cfg_data,
	output logic signed [SAMPLE_W-1:0]   sample_out
);

	localparam sine_tab_t SineRom = build_sine();

	// Configuration and running state
	logic        [PHASE_W-1:0]  phase_step_q;
	logic signed [GAIN_W-1:0]   mix_gain_q;
	logic        [PHASE_W-1:0]  phase_q;
	logic        [RING_AW-1:0]  wptr_q;
	logic        [COUNT_W-1:0]  count_q;

	// Per-sample working registers
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SINE_W-1:0]   sine_q;
	logic        [DINT_W-1:0]   dint_q;
	logic        [FRAC_W-1:0]   fr_q;
	logic        [RING_AW-1:0]  ia_q;
	logic        [RING_AW-1:0]  ib_q;
	logic                       run_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [SAMPLE_W-1:0] a_q;
	logic signed [MIX_W-1:0]    mix_q;
	logic signed [PROD_W-1:0]   p_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];

	// Delay computation
	logic        [SINE_W-1:0]        sine_off;
	logic        [SINE_W+DM_W-1:0]   dprod;
	logic        [DQ_W-1:0]          dq;

	// Ring addressing
	logic        [RING_AW-1:0]  dint_r;
	logic        [RING_AW:0]    wrap_a;
	logic        [RING_AW:0]    wrap_b;
	logic        [RING_AW-1:0]  ia_d;
	logic        [RING_AW-1:0]  ib_d;
	logic        [RING_AW-1:0]  rd_addr;

	// Interpolation and output
	logic signed [SAMPLE_W:0]   diff;
	logic signed [FRAC_W:0]     fr_s;
	logic signed [MIX_W-1:0]    dmul;
	logic signed [MIX_W-1:0]    a_sh;
	logic signed [PROD_W-1:0]   rnd;
	logic signed [ADD_W-1:0]    add_s;
	logic signed [SUM_W-1:0]    sum;
	logic [SUM_W-SAMPLE_W:0]    upper;
	logic signed [SAMPLE_W-1:0] sat;
	logic signed [SAMPLE_W-1:0] y;

	// Delay in Q.8 = DELAY_MAX * (sine + 0.5 full scale) scaled back
	assign sine_off = {~sine_q[SINE_W-1], sine_q[SINE_W-2:0]};
	assign dprod    = sine_off * DM_W'(DELAY_MAX);
	assign dq       = dprod[DQ_SHIFT +: DQ_W];

	// Tap addresses behind the write pointer, modulo the ring depth
	assign dint_r = RING_AW'(dint_q);
	assign wrap_a = {1'b0, wptr_q} + (RING_AW+1)'(RING_DEPTH) - {1'b0, dint_r};
	assign wrap_b = wrap_a - (RING_AW+1)'(1);
	assign ia_d   = (wptr_q >= dint_r) ? (wptr_q - dint_r) : wrap_a[RING_AW-1:0];
	assign ib_d   = (wptr_q > dint_r) ? (wptr_q - dint_r - RING_AW'(1)) : wrap_b[RING_AW-1:0];
	assign rd_addr = cmd.rda ? ia_q : ib_q;

	// Linear interpolation as a*256 + (b - a)*fr
	assign diff = {rd_q[SAMPLE_W-1], rd_q} - {a_q[SAMPLE_W-1], a_q};
	assign fr_s = {1'b0, fr_q};
	assign dmul = diff * fr_s;
	assign a_sh = {{(MIX_W-SAMPLE_W-FRAC_W){a_q[SAMPLE_W-1]}}, a_q, {FRAC_W{1'b0}}};

	// Round half up to Q.15, add the dry sample, saturate
	assign rnd   = p_q + (PROD_W'(1) <<< (RND_SHIFT - 1));
	assign add_s = rnd[PROD_W-1:RND_SHIFT];
	assign sum   = SUM_W'(add_s) + SUM_W'(x_q);
	assign upper = sum[SUM_W-1:SAMPLE_W-1];

	always_comb begin
		if ((&upper) || !(|upper)) begin
			sat = sum[SAMPLE_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// Pass the dry sample through during warm-up
	assign y = run_q ? sat : x_q;

	assign sample_out = sample_out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			mix_gain_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PHASE_STEP: phase_step_q <= cfg_data[PHASE_W-1:0];
				REG_MIX_GAIN:   mix_gain_q   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// LFO phase, write pointer and warm-up counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			wptr_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept && start_of_signal) begin
			phase_q <= '0;
			count_q <= '0;
		end else if (cmd.out_load) begin
			phase_q <= phase_q + phase_step_q;
			wptr_q  <= (wptr_q == RING_AW'(RING_DEPTH - 1)) ? '0 : wptr_q + RING_AW'(1);
			if (count_q < COUNT_W'(COUNT_MAX)) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	// Working registers, one group per sequencer step
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q <= sample_in;
		end
		if (cmd.sine) begin
			sine_q <= SineRom[phase_q[PHASE_W-1 -: SINE_AW]];
		end
		if (cmd.delay) begin
			dint_q <= dq[DQ_W-1:FRAC_W];
			fr_q   <= dq[FRAC_W-1:0];
		end
		if (cmd.addr) begin
			ia_q  <= ia_d;
			ib_q  <= ib_d;
			run_q <= (count_q > COUNT_W'(dint_q));
		end
		if (cmd.rdb) begin
			a_q <= rd_q;
		end
		if (cmd.mix) begin
			mix_q <= a_sh + dmul;
		end
		if (cmd.mul) begin
			p_q <= mix_gain_q * mix_q;
		end
		if (cmd.out_load) begin
			sample_out_q <= y;
		end
	end

	// History ring: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.sine) begin
			ring_mem[wptr_q] <= x_q;
		end
		if (cmd.rda || cmd.rdb) begin
			rd_q <= ring_mem[rd_addr];
		end
	end

endmodule

[rtl/sine_lfo_flanger_top.sv]
// Sine-LFO flanger with linearly interpolated delay of up to DELAY_MAX samples:
// each accepted sample is written to a 258-entry history ring, the LFO phase
// picks a sine ROM entry that sets the delay in Q.8, and the two neighboring
// delayed samples are interpolated, scaled by mix_gain and added to the input,
// saturated to 16 bits. Until enough samples have arrived since reset or
// start_of_signal, the input passes through unchanged. The result register
// loads once the sequencer has stepped through ROM read, delay scaling,
// address calculation, two reads of the single-port ring, interpolation,
// gain multiply and rounding. It returns to idle in the cycle after the
// load, and only then is a new sample taken; while the result register is
// full and not drained, the sequencer waits in its last step and in_ready
// stays low. cfg writes are taken at any time and must only be issued while
// no sample is in flight.
// Depends on slf_pkg, slf_ctrl and slf_dpath.
module sine_lfo_flanger_top import slf_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [SAMPLE_W-1:0]   sample_in,
	input  logic                         start_of_signal,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [SAMPLE_W-1:0]   sample_out,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic        [CFG_IDX_W-1:0]  cfg_index,
	input  logic        [CFG_DATA_W-1:0] cfg_data
);

	slf_cmd_t cmd;
	logic     cfg_we;

	// Register writes never stall
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	slf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	slf_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sample_in       (sample_in),
		.start_of_signal (start_of_signal),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample_out      (sample_out)
	);

endmodule

[test/sine_lfo_flanger_top_tb.sv]
// Self-checking testbench for sine_lfo_flanger_top: drives samples and register writes
// over valid/ready channels and checks every output against a built-in flanger predictor.
// Depends on slf_pkg and the flanger RTL.
`timescale 1ns / 100ps

module sine_lfo_flanger_top_tb;
	import slf_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 11;
	localparam int DRAIN_PAUSE    = 16;
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int HOLD_CYCLES    = 400;
	localparam int REPORT_LIMIT   = 10;

	// Indexes outside the register map; writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

	// DUT ports, with the inputs known from time zero
	logic                         clk             = 1'b0;
	logic                         arst_n          = 1'b0;
	logic                         in_valid        = 1'b0;
	logic signed [SAMPLE_W-1:0]   sample_in       = '0;
	logic                         start_of_signal = 1'b0;
	logic                         out_ready       = 1'b0;
	logic                         cfg_valid       = 1'b0;
	logic        [CFG_IDX_W-1:0]  cfg_index       = '0;
	logic        [CFG_DATA_W-1:0] cfg_data        = '0;
	logic                         in_ready;
	logic                         out_valid;
	logic signed [SAMPLE_W-1:0]   sample_out;
	logic                         cfg_ready;

	// Predictor state
	int                           sine_rom [SINE_DEPTH];
	logic signed [SAMPLE_W-1:0]   ring_mem [RING_DEPTH];
	int                           wr_ptr     = 0;
	int                           warm_count = 0;
	logic        [PHASE_W-1:0]    lfo_acc    = '0;
	logic        [PHASE_W-1:0]    step_reg   = '0;
	logic signed [GAIN_W-1:0]     gain_reg   = '0;

	logic signed [SAMPLE_W-1:0]   pending_outputs [$];

	// Run control and bookkeeping
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int hold_request    = 0;
	int hold_left       = 0;
	int fail_count      = 0;
	int mismatch_count  = 0;
	int samples_sent    = 0;
	int results_checked = 0;
	int mixed_count     = 0;
	int settings_count  = 0;

	sine_lfo_flanger_top i_dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Expected output for one accepted sample; advances the predictor state
	function automatic logic signed [SAMPLE_W-1:0] flange_predict(
		input logic signed [SAMPLE_W-1:0] x,
		input logic                       restart
	);
		int     cur;
		int     ia;
		int     ib;
		int     dq;
		int     dint;
		int     frac;
		longint mix;
		longint prod;
		longint y;
		if (restart) begin
			warm_count = 0;
			lfo_acc    = '0;
		end
		cur = wr_ptr;
		ring_mem[cur] = x;
		// Delay in Q.8 from the sine entry picked by the top phase bits
		dq   = (DELAY_MAX * (32768 + sine_rom[lfo_acc[PHASE_W-1 -: SINE_AW]])) >> 8;
		dint = dq >> FRAC_W;
		frac = dq & ((1 << FRAC_W) - 1);
		y    = x;
		if (warm_count >= dint + 1) begin
			ia   = (cur + RING_DEPTH - dint) % RING_DEPTH;
			ib   = (cur + RING_DEPTH - dint - 1) % RING_DEPTH;
			mix  = longint'(ring_mem[ia]) * (256 - frac) + longint'(ring_mem[ib]) * frac;
			prod = longint'(gain_reg) * mix;
			// Q.37 back to Q.15, round half up
			y    = x + ((prod + (longint'(1) << 21)) >>> RND_SHIFT);
			if (y > 32767) y = 32767;
			if (y < -32768) y = -32768;
			mixed_count++;
		end
		wr_ptr = (cur + 1) % RING_DEPTH;
		if (warm_count < COUNT_MAX) warm_count++;
		lfo_acc = lfo_acc + step_reg;
		return y[SAMPLE_W-1:0];
	endfunction

	// Mostly random samples, with the rails showing up often
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return r[SAMPLE_W-1:0];
		endcase
	endfunction

	// One register write; valid is left high so back-to-back writes stay clean
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PHASE_STEP: step_reg = data;
			REG_MIX_GAIN:   gain_reg = data[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [PHASE_W-1:0] step, input logic signed [GAIN_W-1:0] gain);
		logic [31:0] noise;
		noise = $urandom();
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_MIX_GAIN, {noise[31:16], gain});
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	// One sample transfer, with random gaps in front of it
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic restart);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		sample_in       <= value;
		start_of_signal <= restart;
		do @(posedge clk); while (!in_ready);
		pending_outputs.push_back(flange_predict(value, restart));
		samples_sent++;
	endtask

	// Stop offering and let every expected output come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// Registers still at reset: zero step and zero gain, pure pass-through
	task automatic test_reset_defaults();
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh0000, 1'b0);
		wait_idle();
	endtask

	// Three-quarter-turn phase step: every fourth sample lands on the shortest delay,
	// rails in the input drive the sum into saturation both ways
	task automatic test_short_delay_extremes();
		logic signed [GAIN_W-1:0] gains [2];
		gains[0] = 16'sh7FFF;
		gains[1] = 16'sh8000;
		foreach (gains[g]) begin
			configure(32'hC000_0000, gains[g]);
			send_sample(16'sh7FFF, 1'b1);
			send_sample(16'sh7FFF, 1'b0);
			send_sample(16'sh8000, 1'b0);
			send_sample(16'sh8000, 1'b0);
			send_sample(16'sh0000, 1'b0);
			send_sample(16'sh8000, 1'b0);
			send_sample(16'shFFFF, 1'b0);
			send_sample(16'sh0001, 1'b1);
			wait_idle();
		end
	endtask

	// Writes to unmapped indexes must leave both registers alone
	task automatic test_unused_index();
		write_reg(REG_PHASE_STEP, 32'hC000_0000);
		write_reg(REG_MIX_GAIN, 32'h0000_4000);
		write_reg(CFG_IDX_SPARE2, '1);
		write_reg(CFG_IDX_SPARE3, '1);
		cfg_valid <= 1'b0;
		settings_count++;
		send_sample(pick_sample(), 1'b1);
		repeat (5) send_sample(pick_sample(), 1'b0);
		wait_idle();
	endtask

	// Long runs of samples so the delay line fills, with rare restarts and restart bursts
	task automatic test_random_traffic(
		input int                       count,
		input logic [PHASE_W-1:0]       step,
		input logic signed [GAIN_W-1:0] gain
	);
		int restart_left;
		restart_left = 0;
		configure(step, gain);
		repeat (count) begin
			if ($urandom_range(499) == 0) restart_left = $urandom_range(4, 1);
			send_sample(pick_sample(), restart_left > 0);
			if (restart_left > 0) restart_left--;
		end
		wait_idle();
	endtask

	// Output side stalls for a long stretch while samples keep coming
	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		repeat (40) send_sample(pick_sample(), 1'b0);
		wait_idle();
	endtask

	// Output side ready, with random stalls or a requested hold-off
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each output transfer with the oldest prediction
	always @(posedge clk) begin : check_outputs
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_outputs.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("tb: unexpected output %0d at %0t", sample_out, $realtime);
			end else begin
				want = pending_outputs.pop_front();
				if (sample_out !== want) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("tb: output %0d: expected %0d, got %0d",
							results_checked, want, sample_out);
				end
			end
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("tb: failure");
		$finish;
	end

	initial begin
		longint quad;
		longint x;
		longint x2;
		longint p;
		logic [31:0] seed_step;
		logic [31:0] seed_gain;
		// Sine table: odd degree-9 quarter-wave polynomial in Q30, folded to a full period
		for (int k = 0; k < SINE_DEPTH; k++) begin
			quad = (longint'(k) * 4) / SINE_DEPTH;
			x    = (((longint'(k) * 4) % SINE_DEPTH) * 65536) / SINE_DEPTH;
			if (quad % 2 == 1) x = 65536 - x;
			x2 = (x * x) / 65536;
			p  = 172228;
			p  = -5027044 + (p * x2) / 65536;
			p  = 85569278 + (p * x2) / 65536;
			p  = -693598676 + (p * x2) / 65536;
			p  = 1686629713 + (p * x2) / 65536;
			p  = (p * x) / 65536;
			if (p < 0) p = 0;
			p = (p + 16384) / 32768;
			if (p > 32767) p = 32767;
			sine_rom[k] = ((quad / 2) % 2 == 1) ? -p : p;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 61;
		test_reset_defaults();
		test_short_delay_extremes();
		test_unused_index();
		test_random_traffic(450, 32'hFFFF_FFFF, 16'sh8000);

		send_idle_pct = 61;
		recv_idle_pct = 34;
		seed_step = $urandom();
		seed_gain = $urandom();
		test_random_traffic(450, seed_step, seed_gain[GAIN_W-1:0]);
		test_backpressure();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(420, 32'd0, 16'sh7FFF);
		seed_step = $urandom_range(32'h0100_0000);
		seed_gain = $urandom();
		test_random_traffic(430, seed_step, seed_gain[GAIN_W-1:0]);

		fail_count += pending_outputs.size();
		$display("Flanger run: %0d samples over %0d register settings, %0d outputs checked,",
			samples_sent, settings_count, results_checked);
		$display("  %0d of them through the interpolated delay path, %0d mismatches",
			mixed_count, mismatch_count);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/slf_pkg.sv
rtl/slf_ctrl.sv
rtl/slf_dpath.sv
rtl/sine_lfo_flanger_top.sv
test/sine_lfo_flanger_top_tb.sv
